// ===== sv/aes_pkg.sv =====
`timescale 1ns / 1ps

package aes_pkg;

	typedef logic [7:0] byte_tbl_t [256];

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] x;
		logic [7:0] y;
		p = 8'h00;
		x = a;
		y = b;
		for (int i = 0; i < 8; i++) begin
			if (y[0]) begin
				p = p ^ x;
			end
			x = x[7] ? ({x[6:0], 1'b0} ^ 8'h1b) : {x[6:0], 1'b0};
			y = {1'b0, y[7:1]};
		end
		return p;
	endfunction

	function automatic logic [7:0] gf_inv(input logic [7:0] x);
		logic [7:0] r;
		logic [7:0] b;
		logic [7:0] e;
		r = 8'h01;
		b = x;
		e = 8'd254;
		for (int i = 0; i < 8; i++) begin
			if (e[i]) begin
				r = gf_mul(r, b);
			end
			b = gf_mul(b, b);
		end
		return r;
	endfunction

	function automatic byte_tbl_t gen_fwd();
		byte_tbl_t t;
		logic [7:0] b;
		for (int x = 0; x < 256; x++) begin
			b = gf_inv(8'(x));
			t[x] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
				^ {b[3:0], b[7:4]} ^ 8'h63;
		end
		return t;
	endfunction

	function automatic byte_tbl_t gen_inv();
		byte_tbl_t f;
		byte_tbl_t t;
		f = gen_fwd();
		for (int x = 0; x < 256; x++) begin
			t[f[x]] = 8'(x);
		end
		return t;
	endfunction

	localparam byte_tbl_t SBOX_FWD = gen_fwd();
	localparam byte_tbl_t SBOX_INV = gen_inv();

	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	function automatic logic [7:0] rcon(input int idx);
		logic [7:0] r;
		r = 8'h01;
		for (int i = 0; i < idx; i++) begin
			r = gf_mul(r, 8'h02);
		end
		return r;
	endfunction

	function automatic logic [127:0] sub_bytes(input logic [127:0] v, input logic inv);
		logic [127:0] o;
		for (int i = 0; i < 16; i++) begin
			o[127-8*i -: 8] = inv ? SBOX_INV[v[127-8*i -: 8]] : SBOX_FWD[v[127-8*i -: 8]];
		end
		return o;
	endfunction

	function automatic logic [127:0] shift_rows(input logic [127:0] v, input logic inv);
		logic [127:0] o;
		int src;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				src = inv ? ((c - r + 4) & 3) : ((c + r) & 3);
				o[127-8*(4*c+r) -: 8] = v[127-8*(4*src+r) -: 8];
			end
		end
		return o;
	endfunction

	function automatic logic [7:0] mix_coef(input int k, input logic inv);
		logic [7:0] m;
		case (k)
			0: m = inv ? 8'd14 : 8'd2;
			1: m = inv ? 8'd11 : 8'd3;
			2: m = inv ? 8'd13 : 8'd1;
			default: m = inv ? 8'd9 : 8'd1;
		endcase
		return m;
	endfunction

	function automatic logic [127:0] mix_cols(input logic [127:0] v, input logic inv);
		logic [127:0] o;
		logic [7:0] acc;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				acc = 8'h00;
				for (int j = 0; j < 4; j++) begin
					acc = acc ^ gf_mul(v[127-8*(4*c+j) -: 8], mix_coef((j - r + 4) & 3, inv));
				end
				o[127-8*(4*c+r) -: 8] = acc;
			end
		end
		return o;
	endfunction

	function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
		logic [7:0] b [16];
		logic [7:0] t [4];
		logic [127:0] o;
		for (int i = 0; i < 16; i++) begin
			b[i] = k[127-8*i -: 8];
		end
		t[0] = SBOX_FWD[b[13]] ^ rc;
		t[1] = SBOX_FWD[b[14]];
		t[2] = SBOX_FWD[b[15]];
		t[3] = SBOX_FWD[b[12]];
		for (int i = 0; i < 4; i++) begin
			b[i] = b[i] ^ t[i];
		end
		for (int i = 4; i < 16; i++) begin
			b[i] = b[i] ^ b[i-4];
		end
		for (int i = 0; i < 16; i++) begin
			o[127-8*i -: 8] = b[i];
		end
		return o;
	endfunction

	function automatic logic [127:0] prev_key(input logic [127:0] k, input logic [7:0] rc);
		logic [7:0] n [16];
		logic [7:0] b [16];
		logic [127:0] o;
		for (int i = 0; i < 16; i++) begin
			n[i] = k[127-8*i -: 8];
		end
		for (int i = 4; i < 16; i++) begin
			b[i] = n[i] ^ n[i-4];
		end
		b[0] = n[0] ^ SBOX_FWD[b[13]] ^ rc;
		b[1] = n[1] ^ SBOX_FWD[b[14]];
		b[2] = n[2] ^ SBOX_FWD[b[15]];
		b[3] = n[3] ^ SBOX_FWD[b[12]];
		for (int i = 0; i < 16; i++) begin
			o[127-8*i -: 8] = b[i];
		end
		return o;
	endfunction

endpackage

// ===== sv/aes128_block_cipher.sv =====
`timescale 1ns / 1ps

// AES-128 encrypt/decrypt pipeline, one transaction per clock.
// Input: a transaction is taken at a rising edge with start high and busy
// low. command selects encrypt (0) or decrypt (1); key_high/key_low and
// data_high/data_low carry the key and block, byte 0 in the top byte.
// busy is always low: a new transaction may enter every cycle.
// Output: result_valid marks result_high/result_low for exactly one cycle,
// once the transaction has passed all expansion and round stages. Results leave in the
// order transactions entered.
// Structure: ROUNDS stages expand the key to its last round key, each
// stage one key-schedule step; then ROUNDS round stages, each one cipher
// round plus one forward (encrypt) or inverse (decrypt) key-schedule step.
// Throughput is one block per cycle, set by one round of logic per stage.
// Reset clears all stage valid bits; transactions in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
module aes128_block_cipher #(
	parameter int ROUNDS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [63:0] key_high,
	input  logic [63:0] key_low,
	input  logic [63:0] data_high,
	input  logic [63:0] data_low,
	output logic        result_valid,
	output logic [63:0] result_high,
	output logic [63:0] result_low
);

	localparam int LAT = 2 * ROUNDS;

	logic         ev_s   [1:ROUNDS];
	logic         ecmd_s [1:ROUNDS];
	logic [127:0] ekey_s [1:ROUNDS];
	logic [127:0] okey_s [1:ROUNDS];
	logic [127:0] edat_s [1:ROUNDS];

	logic         cv_s   [1:ROUNDS];
	logic         ccmd_s [1:ROUNDS];
	logic [127:0] ckey_s [1:ROUNDS];
	logic [127:0] cst_s  [1:ROUNDS];

	logic accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	for (genvar p = 1; p <= ROUNDS; p++) begin : g_exp
		logic         v_in;
		logic         cmd_in;
		logic [127:0] key_in;
		logic [127:0] org_in;
		logic [127:0] dat_in;

		if (p == 1) begin : g_first
			assign v_in   = accept;
			assign cmd_in = command;
			assign key_in = {key_high, key_low};
			assign org_in = {key_high, key_low};
			assign dat_in = {data_high, data_low};
		end else begin : g_next
			assign v_in   = ev_s[p-1];
			assign cmd_in = ecmd_s[p-1];
			assign key_in = ekey_s[p-1];
			assign org_in = okey_s[p-1];
			assign dat_in = edat_s[p-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ev_s[p] <= 1'b0;
			end else begin
				ev_s[p] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			ecmd_s[p] <= cmd_in;
			ekey_s[p] <= aes_pkg::next_key(key_in, aes_pkg::rcon(p - 1));
			okey_s[p] <= org_in;
			edat_s[p] <= dat_in;
		end
	end

	for (genvar j = 1; j <= ROUNDS; j++) begin : g_rnd
		localparam logic [7:0] RC_ENC = aes_pkg::rcon(j - 1);
		localparam logic [7:0] RC_DEC = aes_pkg::rcon(ROUNDS - j);

		logic         v_in;
		logic         cmd_in;
		logic [127:0] key_in;
		logic [127:0] st_in;
		logic [127:0] key_nx;
		logic [127:0] enc_t;
		logic [127:0] dec_t;
		logic [127:0] st_nx;

		if (j == 1) begin : g_first
			assign v_in   = ev_s[ROUNDS];
			assign cmd_in = ecmd_s[ROUNDS];
			assign key_in = (ecmd_s[ROUNDS] == aes_pkg::CMD_DECRYPT) ?
				ekey_s[ROUNDS] : okey_s[ROUNDS];
			assign st_in  = edat_s[ROUNDS] ^ key_in;
		end else begin : g_next
			assign v_in   = cv_s[j-1];
			assign cmd_in = ccmd_s[j-1];
			assign key_in = ckey_s[j-1];
			assign st_in  = cst_s[j-1];
		end

		always_comb begin
			if (cmd_in == aes_pkg::CMD_DECRYPT) begin
				key_nx = aes_pkg::prev_key(key_in, RC_DEC);
			end else begin
				key_nx = aes_pkg::next_key(key_in, RC_ENC);
			end
			enc_t = aes_pkg::shift_rows(aes_pkg::sub_bytes(st_in, 1'b0), 1'b0);
			if (j < ROUNDS) begin
				enc_t = aes_pkg::mix_cols(enc_t, 1'b0);
			end
			enc_t = enc_t ^ key_nx;
			dec_t = aes_pkg::shift_rows(aes_pkg::sub_bytes(st_in, 1'b1), 1'b1) ^ key_nx;
			if (j < ROUNDS) begin
				dec_t = aes_pkg::mix_cols(dec_t, 1'b1);
			end
			st_nx = (cmd_in == aes_pkg::CMD_DECRYPT) ? dec_t : enc_t;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[j] <= 1'b0;
			end else begin
				cv_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			ccmd_s[j] <= cmd_in;
			ckey_s[j] <= key_nx;
			cst_s[j]  <= st_nx;
		end
	end

	assign result_valid = cv_s[ROUNDS];
	assign result_high  = cst_s[ROUNDS][127:64];
	assign result_low   = cst_s[ROUNDS][63:0];

	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start, LAT))
		else $error("result without a transaction LAT cycles earlier");

	a_expand_to_round: assert property (@(posedge clk) disable iff (!arst_n)
		ev_s[ROUNDS] |=> cv_s[1])
		else $error("transaction lost between key expansion and rounds");

	a_round_cmd_kept: assert property (@(posedge clk) disable iff (!arst_n)
		ev_s[ROUNDS] |=> (ccmd_s[1] == $past(ecmd_s[ROUNDS])))
		else $error("command changed entering the round stages");

endmodule
